### src/gkg_pkg.sv
`timescale 1ns / 1ps
// Package for the Gaussian kernel generator: payload structs, the sequencer
// state type and fixed-point constants. No dependencies.
package gkg_pkg;

    typedef struct packed {
        logic [15:0] sigma;
        logic [4:0]  radius;
    } gkg_in_t;

    typedef struct packed {
        logic signed [5:0] tap_offset;
        logic [15:0]       weight;
        logic              last_tap;
    } gkg_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARG,
        ST_SERIES,
        ST_TERM,
        ST_SCALE,
        ST_STORE,
        ST_SUMFIX,
        ST_RDREQ,
        ST_RDWAIT,
        ST_DIV,
        ST_EMIT
    } gkg_state_t;

    localparam logic [31:0] ONE_Q30      = 32'd1073741824;
    localparam logic [23:0] ONE_Q23      = 24'd8388608;
    localparam logic [29:0] E_INV_Q30    = 30'd395007543;
    localparam int          SERIES_TERMS = 12;

endpackage

### src/gkg_divider.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing.
module gkg_divider #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (go)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial  = {r_reg, q_reg[NW-1]};
            q_next = {q_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = DW'(trial - {1'b0, d_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial[DW-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

### src/gkg_weight_mem.sv
`timescale 1ns / 1ps
// Raw weight store: one write port, one registered read port.
// Depends on nothing.
module gkg_weight_mem #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);
    logic [23:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/gaussian_kernel_generator_top.sv
`timescale 1ns / 1ps
// Top level of the Gaussian kernel generator.
// Depends on gkg_pkg, gkg_divider and gkg_weight_mem.

// A request is taken when start is high and busy is low; busy then stays
// high until the cycle in which the last tap is presented, when it falls so
// that the next request can be transferred at once. The kernel of 2*radius+1
// taps comes out one transfer at a time on result, each marked by a one-cycle
// strobe, from offset -radius to +radius with last_tap on the final one.
// The receiver cannot stall, so every transfer must be captured in the cycle
// it appears. Work happens in two passes over the weight memory. In the first,
// each tap takes a serial division that forms the exponent argument, then the
// 12 series terms, each divided serially by its index, then scaling and one
// store; a tap whose argument reaches 17 skips the series and scaling, and a
// tap of a zero sigma goes straight to its store. A further state then fixes
// a zero sum. In the second pass each tap takes a read request, a read, a
// serial division and an emit, and its transfer is presented in the cycle
// after the emit. The run time is set by the serial dividers. Radius above
// MAX_RADIUS saturates.
module gaussian_kernel_generator_top
    import gkg_pkg::*;
#(
    parameter int MAX_RADIUS = 31
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  gkg_in_t  request,
    output logic     strobe,
    output gkg_out_t result
);
    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);

    gkg_state_t state_reg, state_next;

    logic [15:0]   sigma_reg;
    logic [4:0]    rad_reg;
    logic [AW-1:0] k_reg;
    logic [3:0]    term_k_reg;
    logic [4:0]    whole_reg;
    logic [15:0]   frac_reg;
    logic [31:0]   term_reg, pos_reg, neg_reg;
    logic [31:0]   r_reg;
    logic [31:0]   sum_reg;
    logic          strobe_reg;
    gkg_out_t      result_reg;

    // Radius of an incoming request, saturated to MAX_RADIUS.
    logic [4:0] rad_in;
    assign rad_in = (request.radius > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : request.radius;

    // Signed offset of the current tap and of the one after it, and the
    // squares that feed the argument division.
    logic signed [6:0] off, off_nx;
    logic [9:0]        sq_in;
    logic [13:0]       sq_nx;
    assign off    = $signed(7'(k_reg)) - $signed({2'b0, rad_reg});
    assign off_nx = $signed(7'(k_reg) + 7'd1) - $signed({2'b0, rad_reg});
    assign sq_in  = {5'd0, rad_in} * {5'd0, rad_in};
    assign sq_nx  = {{7{off_nx[6]}}, off_nx} * {{7{off_nx[6]}}, off_nx};

    // Shared divider for the argument and the normalisation.
    logic        div_go, div_done;
    logic [63:0] div_num, div_q;
    logic [31:0] div_den;
    gkg_divider #(.NW(64), .DW(32)) u_div (
        .clk (clk), .rst_n (rst_n), .go (div_go), .num (div_num),
        .den (div_den), .done (div_done), .quot (div_q)
    );

    // Series step: the scaled term is divided by its index.
    logic [47:0] tf;
    logic        tdiv_go, tdiv_done;
    logic [31:0] tdiv;
    assign tf = {16'd0, term_reg} * {32'd0, frac_reg};
    gkg_divider #(.NW(32), .DW(4)) u_tdiv (
        .clk (clk), .rst_n (rst_n), .go (tdiv_go), .num (tf[47:16]),
        .den (term_k_reg), .done (tdiv_done), .quot (tdiv)
    );

    // Weight memory.
    logic        mem_we;
    logic [23:0] mem_wdata, mem_rdata;
    gkg_weight_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk (clk), .we (mem_we), .waddr (k_reg), .wdata (mem_wdata),
        .raddr (k_reg), .rdata (mem_rdata)
    );

    // Scaling step and final rounding.
    logic [61:0] sprod;
    logic [24:0] rnd;
    logic [23:0] wraw;
    assign sprod = {30'd0, r_reg} * {32'd0, E_INV_Q30} + 62'd536870912;
    assign rnd   = 25'((r_reg + 32'd64) >> 7);
    assign wraw  = (rnd > {1'b0, ONE_Q23}) ? ONE_Q23 : rnd[23:0];

    logic last_k;
    assign last_k = (7'(k_reg) == {1'b0, rad_reg, 1'b0});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_ARG;
            ST_ARG:
            begin
                if (sigma_reg == 16'd0) state_next = ST_STORE;
                else if (div_done)      state_next = ST_SERIES;
            end
            ST_SERIES:
            begin
                if (whole_reg >= 5'd17) state_next = ST_STORE;
                else                    state_next = ST_TERM;
            end
            ST_TERM:
            begin
                if (tdiv_done)
                begin
                    if (term_k_reg == 4'(SERIES_TERMS)) state_next = ST_SCALE;
                    else                                state_next = ST_SERIES;
                end
            end
            ST_SCALE:  if (whole_reg == 5'd0) state_next = ST_STORE;
            ST_STORE:  state_next = last_k ? ST_SUMFIX : ST_ARG;
            ST_SUMFIX: state_next = ST_RDREQ;
            ST_RDREQ:  state_next = ST_RDWAIT;
            ST_RDWAIT: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_EMIT;
            ST_EMIT:   state_next = last_k ? ST_IDLE : ST_RDREQ;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_go    = 1'b0;
        div_num   = '0;
        div_den   = '0;
        tdiv_go   = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Argument i*i*2^31 / sigma^2 for the first tap.
                if (start && request.sigma != 16'd0)
                begin
                    div_go  = 1'b1;
                    div_num = {23'd0, sq_in, 31'd0};
                    div_den = {16'd0, request.sigma} * {16'd0, request.sigma};
                end
            end
            ST_SERIES:
            begin
                tdiv_go = (whole_reg < 5'd17);
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                if (sigma_reg == 16'd0)
                    mem_wdata = (off == 7'sd0) ? ONE_Q23 : 24'd0;
                else if (whole_reg >= 5'd17)
                    mem_wdata = 24'd0;
                else
                    mem_wdata = wraw;
                // Argument for the next tap.
                if (!last_k && sigma_reg != 16'd0)
                begin
                    div_go  = 1'b1;
                    div_num = {19'd0, sq_nx, 31'd0};
                    div_den = {16'd0, sigma_reg} * {16'd0, sigma_reg};
                end
            end
            ST_RDWAIT:
            begin
                div_go  = 1'b1;
                div_num = ({40'd0, mem_rdata} << 15) + {33'd0, sum_reg[31:1]};
                div_den = sum_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_EMIT);
            if (state_reg == ST_IDLE && start)
                sum_reg <= '0;
            else if (state_reg == ST_STORE)
                sum_reg <= sum_reg + {8'd0, mem_wdata};
            else if (state_reg == ST_SUMFIX && sum_reg == 32'd0)
                sum_reg <= {8'd0, ONE_Q23};
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sigma_reg <= request.sigma;
                rad_reg   <= rad_in;
                k_reg     <= '0;
            end
            ST_ARG:
            begin
                if (div_done)
                begin
                    whole_reg  <= (div_q[63:16] >= 48'd17) ? 5'd17 : div_q[20:16];
                    frac_reg   <= div_q[15:0];
                    term_reg   <= ONE_Q30;
                    pos_reg    <= ONE_Q30;
                    neg_reg    <= '0;
                    term_k_reg <= 4'd1;
                end
            end
            ST_TERM:
            begin
                if (tdiv_done)
                begin
                    term_reg   <= tdiv;
                    term_k_reg <= term_k_reg + 4'd1;
                    if (term_k_reg[0]) neg_reg <= neg_reg + tdiv;
                    else               pos_reg <= pos_reg + tdiv;
                    if (term_k_reg == 4'(SERIES_TERMS))
                        r_reg <= (term_k_reg[0]) ? ((pos_reg > neg_reg + tdiv) ?
                                 pos_reg - neg_reg - tdiv : 32'd0)
                                 : ((pos_reg + tdiv > neg_reg) ?
                                 pos_reg + tdiv - neg_reg : 32'd0);
                end
            end
            ST_SCALE:
            begin
                if (whole_reg != 5'd0)
                begin
                    r_reg     <= 32'(sprod >> 30);
                    whole_reg <= whole_reg - 5'd1;
                end
            end
            ST_STORE:  k_reg <= last_k ? '0 : k_reg + AW'(1);
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_reg.tap_offset <= 6'(off);
                    result_reg.weight     <= div_q[15:0];
                    result_reg.last_tap   <= last_k;
                end
            end
            ST_EMIT:   k_reg <= last_k ? '0 : k_reg + AW'(1);
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;
endmodule

### verif/gkg_checker.sv
`timescale 1ns / 1ps
// Checker for the Gaussian kernel generator: watches request and tap transfers,
// predicts every kernel and compares taps in order. Depends on gkg_pkg.
module gkg_checker
    import gkg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  gkg_in_t  request,
    input  logic     strobe,
    input  gkg_out_t result,
    output int       fail_count,
    output int       taps_pending
);

    localparam int RADIUS_LIMIT = 31;
    localparam logic [63:0] INV_E = 64'd395007543;

    gkg_out_t tap_queue[$];

    // Unnormalised tap weight exp(-a) in Q1.23 from an argument in Q16.16.
    function automatic logic [23:0] raw_weight(logic [63:0] arg_q);
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] acc;
        begin
            whole = arg_q >> 16;
            frac  = {48'd0, arg_q[15:0]};
            pos   = 64'd1073741824;
            neg   = 64'd0;
            term  = 64'd1073741824;
            if (whole >= 64'd17)
                return 24'd0;
            for (int k = 1; k <= SERIES_TERMS; k++)
            begin
                term = ((term * frac) >> 16) / k;
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            acc = (pos > neg) ? pos - neg : 64'd0;
            for (int k = 0; k < whole; k++)
                acc = (acc * INV_E + (64'd1 << 29)) >> 30;
            acc = (acc + 64'd64) >> 7;
            if (acc > 64'd8388608)
                acc = 64'd8388608;
            return acc[23:0];
        end
    endfunction

    // Works out the whole normalised kernel and queues its taps.
    task automatic queue_kernel(gkg_in_t req);
        logic [23:0] weights[63];
        logic [63:0] total;
        logic [31:0] norm;
        logic [63:0] sq;
        logic [63:0] sig;
        logic [63:0] quot;
        int          rad;
        int          taps;
        int          offs;
        gkg_out_t    tap;
        begin
            rad   = (req.radius > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(req.radius);
            taps  = 2 * rad + 1;
            sig   = {48'd0, req.sigma};
            total = 64'd0;
            for (int k = 0; k < taps; k++)
            begin
                offs = k - rad;
                if (sig == 0)
                    weights[k] = (offs == 0) ? ONE_Q23 : 24'd0;
                else
                begin
                    sq = 64'(offs * offs);
                    weights[k] = raw_weight((sq << 31) / (sig * sig));
                end
                total += weights[k];
            end
            norm = total[31:0];
            if (norm == 0)
                norm = {8'd0, ONE_Q23};
            for (int k = 0; k < taps; k++)
            begin
                quot = ({40'd0, weights[k]} * 64'd32768 + {33'd0, norm[31:1]})
                       / {32'd0, norm};
                tap.tap_offset = 6'(k - rad);
                tap.weight     = quot[15:0];
                tap.last_tap   = (k == taps - 1);
                tap_queue = {tap_queue, tap};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count   <= 0;
            taps_pending <= 0;
            tap_queue.delete();
        end
        else
        begin
            if (start && !busy)
                queue_kernel(request);
            if (strobe)
            begin
                if (tap_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected tap transfer: offset %0d weight %0d last %0b",
                                 result.tap_offset, result.weight, result.last_tap);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    gkg_out_t want;
                    want = tap_queue.pop_front();
                    if (want !== result)
                    begin
                        // Values are given as offset/weight/last.
                        if (fail_count < 10)
                            $display("Tap mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.tap_offset, want.weight, want.last_tap,
                                     result.tap_offset, result.weight, result.last_tap);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            taps_pending <= tap_queue.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the Gaussian kernel generator: makes requests, runs the
// watchdog and gives the verdict. Depends on gkg_pkg, gkg_checker and the DUT.
module tb_top;
    import gkg_pkg::*;

    localparam int RANDOM_REQUESTS = 310;
    localparam int STALL_LIMIT     = 150000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    gkg_in_t  request;
    logic     strobe;
    gkg_out_t result;
    int       fail_count;
    int       taps_pending;
    int       idle_cycles;

    gaussian_kernel_generator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    gkg_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .strobe       (strobe),
        .result       (result),
        .fail_count   (fail_count),
        .taps_pending (taps_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The watchdog counts cycles in which neither a request nor a tap is
    // transferred. A full 63-tap kernel spends its whole first pass before the
    // first tap appears, so the limit is set well beyond the length of that pass.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. The start
    // line is left high afterwards; the caller lowers it for a pause or a drain.
    task automatic send_request(logic [15:0] sig, logic [4:0] rad);
        begin
            request.sigma  <= sig;
            request.radius <= rad;
            start          <= 1'b1;
            do
                @(posedge clk);
            while (busy);
        end
    endtask

    // A burst with start low; its length is drawn at random.
    task automatic pause_sender();
        int gap;
        begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] sig;
        logic [4:0]  rad;
        int          pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the delta and single-tap special cases, the widest
        // kernel, sigma at both extremes, a tiny sigma where every side tap
        // underflows to zero, and radius values that set each bit on its own.
        send_request(16'd0,      5'd0);
        send_request(16'd0,      5'd31);
        send_request(16'hFFFF,   5'd0);
        send_request(16'd256,    5'd0);
        send_request(16'hFFFF,   5'd31);
        send_request(16'd1,      5'd31);
        send_request(16'd1,      5'd1);
        send_request(16'd256,    5'd3);
        send_request(16'd512,    5'd8);
        send_request(16'd128,    5'd2);
        send_request(16'h8000,   5'd16);
        send_request(16'h00FF,   5'd4);
        send_request(16'h0100,   5'd31);
        send_request(16'h0A00,   5'd31);
        send_request(16'h5555,   5'd21);
        send_request(16'hAAAA,   5'd10);
        send_request(16'd0,      5'd5);
        send_request(16'd64,     5'd6);
        send_request(16'd3,      5'd7);
        send_request(16'd1000,   5'd15);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Most kernels are kept small since the block is serial and slow;
            // a few reach the full width.
            pick = $urandom_range(0, 99);
            if (pick < 80)
                rad = 5'($urandom_range(0, 5));
            else if (pick < 95)
                rad = 5'($urandom_range(6, 15));
            else
                rad = 5'($urandom_range(16, 31));

            pick = $urandom_range(0, 99);
            if (pick < 5)
                sig = 16'd0;
            else if (pick < 40)
                sig = 16'($urandom_range(1, 2047));
            else
                sig = 16'($urandom);

            // Once, mid-run, the sender waits for the block to drain.
            if (n == RANDOM_REQUESTS / 2)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (taps_pending != 0 || busy);
            end
            else if (n < RANDOM_REQUESTS - 40 && $urandom_range(0, 2) == 0)
                pause_sender();

            send_request(sig, rad);
        end
        start <= 1'b0;

        // Let the last kernel drain, then a short grace period for stray taps.
        do
            @(posedge clk);
        while (taps_pending != 0 || busy);
        repeat (200) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
